// ===== rtl/brr_pkg.sv =====
// ----------------------------------------------------------------------------
// brr_pkg
// Shared types, widths and codes of the bilinear RGB resize core.
// ----------------------------------------------------------------------------
package brr_pkg;

  localparam int MAX_SRC_WIDTH_DEF  = 512;
  localparam int MAX_SRC_HEIGHT_DEF = 512;
  localparam int CHANNELS           = 3;

  localparam int COORD_W = 12;
  localparam int SIZE_W  = 10;
  localparam int STEP_W  = 24;
  localparam int CHAN_W  = 8;
  localparam int FRAC_W  = 8;
  localparam int PIXEL_W = CHANNELS * CHAN_W;
  localparam int PROD_W  = COORD_W + 1 + STEP_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  typedef enum logic {
    CMD_STORE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_STEP_X        = 2'd2,
    REG_STEP_Y        = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] p0;
    logic [COORD_W-1:0] p1;
    logic [FRAC_W-1:0]  frac;
  } loc_t;

endpackage

// ===== rtl/bilinear_resize_rgb_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_resize_rgb_core
// Bilinear RGB resizer with half-pixel centers over a stored source image.
// ----------------------------------------------------------------------------
// One transaction enters per cycle, store or sample alike; a sample's pixel
// passes the input, locate, bank read and blend registers. The four neighbors
// are read together from four banks split by column and row parity, each
// with one write and one read port. The whole pipeline holds while a finished
// pixel waits on m_axis_tready. Stores take effect for every later sample.
module bilinear_resize_rgb_core #(
  parameter int MAX_SRC_WIDTH  = brr_pkg::MAX_SRC_WIDTH_DEF,
  parameter int MAX_SRC_HEIGHT = brr_pkg::MAX_SRC_HEIGHT_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // pos_x[11:0], pos_y[23:12], in_red[31:24], in_green[39:32], in_blue[47:40]
  input  logic [47:0]                     s_axis_tdata,
  // cmd[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16]
  output logic [23:0]                     m_axis_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brr_pkg::*;

  localparam int HALF_W     = (MAX_SRC_WIDTH + 1) / 2;
  localparam int HALF_H     = (MAX_SRC_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH = HALF_W * HALF_H;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic [SIZE_W-1:0]  source_width;
  logic [SIZE_W-1:0]  source_height;
  logic [STEP_W-1:0]  step_x;
  logic [STEP_W-1:0]  step_y;
  logic [COORD_W:0]   size_w;
  logic [COORD_W:0]   size_h;
  logic [COORD_W-1:0] size_m1_x;
  logic [COORD_W-1:0] size_m1_y;

  logic               en;
  logic               v1;
  cmd_e               cmd1;
  logic [COORD_W-1:0] px1;
  logic [COORD_W-1:0] py1;
  logic [PIXEL_W-1:0] rgb1;
  logic               st2, st3;
  logic [COORD_W-1:0] px2, py2, px3, py3;
  logic [PIXEL_W-1:0] rgb2, rgb3;
  logic               store_en;
  logic [BANK_AW-1:0] wr_addr;
  logic               sv2, sv3, sv4, sv5, sv6;
  loc_t               loc_x;
  loc_t               loc_y;
  logic [FRAC_W-1:0]  fx4, fy4;
  logic               x0p4, x1p4, y0p4, y1p4;
  logic [PIXEL_W-1:0] q [2][2];
  logic [PIXEL_W-1:0] pixel;

  assign cfg_ready     = 1'b1;
  assign en            = !sv6 || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = sv6;
  assign m_axis_tdata  = {pixel[7:0], pixel[15:8], pixel[23:16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SIZE_RESET;
      source_height <= SIZE_RESET;
      step_x        <= STEP_RESET;
      step_y        <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_SOURCE_WIDTH:  source_width  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: source_height <= cfg_data[SIZE_W-1:0];
        REG_STEP_X:        step_x        <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:        step_y        <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (source_width == '0) begin
      size_w = (COORD_W+1)'(1);
    end else if ((COORD_W+1)'(source_width) > (COORD_W+1)'(MAX_SRC_WIDTH)) begin
      size_w = (COORD_W+1)'(MAX_SRC_WIDTH);
    end else begin
      size_w = (COORD_W+1)'(source_width);
    end
    if (source_height == '0) begin
      size_h = (COORD_W+1)'(1);
    end else if ((COORD_W+1)'(source_height) > (COORD_W+1)'(MAX_SRC_HEIGHT)) begin
      size_h = (COORD_W+1)'(MAX_SRC_HEIGHT);
    end else begin
      size_h = (COORD_W+1)'(source_height);
    end
    size_m1_x = COORD_W'(size_w - (COORD_W+1)'(1));
    size_m1_y = COORD_W'(size_h - (COORD_W+1)'(1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1 <= cmd_e'(s_axis_tuser);
      px1  <= s_axis_tdata[11:0];
      py1  <= s_axis_tdata[23:12];
      rgb1 <= {s_axis_tdata[31:24], s_axis_tdata[39:32], s_axis_tdata[47:40]};
      px2  <= px1;
      py2  <= py1;
      rgb2 <= rgb1;
      px3  <= px2;
      py3  <= py2;
      rgb3 <= rgb2;
      fx4  <= loc_x.frac;
      fy4  <= loc_y.frac;
      x0p4 <= loc_x.p0[0];
      x1p4 <= loc_x.p1[0];
      y0p4 <= loc_y.p0[0];
      y1p4 <= loc_y.p1[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      st2 <= 1'b0;
      st3 <= 1'b0;
      sv2 <= 1'b0;
      sv3 <= 1'b0;
      sv4 <= 1'b0;
      sv5 <= 1'b0;
      sv6 <= 1'b0;
    end else if (en) begin
      v1  <= s_axis_tvalid;
      st2 <= v1 && (cmd1 == CMD_STORE)
          && ({1'b0, px1} < (COORD_W+1)'(MAX_SRC_WIDTH))
          && ({1'b0, py1} < (COORD_W+1)'(MAX_SRC_HEIGHT));
      st3 <= st2;
      sv2 <= v1 && (cmd1 == CMD_SAMPLE);
      sv3 <= sv2;
      sv4 <= sv3;
      sv5 <= sv4;
      sv6 <= sv5;
    end
  end

  assign store_en = en && st3;
  assign wr_addr  = BANK_AW'(32'(py3[COORD_W-1:1]) * HALF_W + 32'(px3[COORD_W-1:1]));

  brr_locate u_loc_x (
    .clk     (clk),
    .en      (en),
    .pos     (px1),
    .step    (step_x),
    .size_m1 (size_m1_x),
    .loc     (loc_x)
  );

  brr_locate u_loc_y (
    .clk     (clk),
    .en      (en),
    .pos     (py1),
    .step    (step_y),
    .size_m1 (size_m1_y),
    .loc     (loc_y)
  );

  for (genvar by = 0; by < 2; by++) begin : g_row
    for (genvar bx = 0; bx < 2; bx++) begin : g_col
      logic [COORD_W-1:0] rx;
      logic [COORD_W-1:0] ry;
      logic [BANK_AW-1:0] rd_addr;

      assign rx      = (loc_x.p0[0] == 1'(bx)) ? loc_x.p0 : loc_x.p1;
      assign ry      = (loc_y.p0[0] == 1'(by)) ? loc_y.p0 : loc_y.p1;
      assign rd_addr = BANK_AW'(32'(ry[COORD_W-1:1]) * HALF_W + 32'(rx[COORD_W-1:1]));

      brr_bank_ram #(
        .DEPTH  (BANK_DEPTH),
        .ADDR_W (BANK_AW)
      ) u_bank (
        .clk     (clk),
        .wr_en   (store_en && (py3[0] == 1'(by)) && (px3[0] == 1'(bx))),
        .wr_addr (wr_addr),
        .wr_data (rgb3),
        .rd_en   (en),
        .rd_addr (rd_addr),
        .rd_data (q[by][bx])
      );
    end
  end

  brr_blend u_blend (
    .clk   (clk),
    .en    (en),
    .p00   (q[y0p4][x0p4]),
    .p10   (q[y0p4][x1p4]),
    .p01   (q[y1p4][x0p4]),
    .p11   (q[y1p4][x1p4]),
    .fx    (fx4),
    .fy    (fy4),
    .pixel (pixel)
  );

endmodule

// ===== rtl/brr_locate.sv =====
// ----------------------------------------------------------------------------
// brr_locate
// Two-stage source coordinate unit: half-pixel product, then clamp and split.
// ----------------------------------------------------------------------------
module brr_locate (
  input  logic                         clk,
  input  logic                         en,
  input  logic [brr_pkg::COORD_W-1:0]  pos,
  input  logic [brr_pkg::STEP_W-1:0]   step,
  input  logic [brr_pkg::COORD_W-1:0]  size_m1,
  output brr_pkg::loc_t                loc
);
  import brr_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  diff;
  logic [PROD_W-2:0]  spos;
  logic [PROD_W-2:0]  lim;
  logic [PROD_W-2:0]  clamped;
  logic [COORD_W-1:0] p0;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'({pos, 1'b1}) * PROD_W'(step);
    end
  end

  always_comb begin
    diff    = prod - PROD_W'(65536);
    spos    = (prod >= PROD_W'(65536)) ? diff[PROD_W-1:1] : '0;
    lim     = (PROD_W-1)'({size_m1, 16'b0});
    clamped = (spos > lim) ? lim : spos;
    p0      = clamped[16 +: COORD_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc.p0   <= p0;
      loc.p1   <= (p0 < size_m1) ? p0 + COORD_W'(1) : size_m1;
      loc.frac <= clamped[15:8];
    end
  end

endmodule

// ===== rtl/brr_bank_ram.sv =====
// ----------------------------------------------------------------------------
// brr_bank_ram
// One parity bank of the source image: one write port, one registered read.
// ----------------------------------------------------------------------------
module brr_bank_ram #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [brr_pkg::PIXEL_W-1:0]  wr_data,
  input  logic                         rd_en,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [brr_pkg::PIXEL_W-1:0]  rd_data
);
  import brr_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/brr_blend.sv =====
// ----------------------------------------------------------------------------
// brr_blend
// Two-stage per-channel blend: horizontal rows, then vertical mix.
// ----------------------------------------------------------------------------
module brr_blend (
  input  logic                         clk,
  input  logic                         en,
  input  logic [brr_pkg::PIXEL_W-1:0]  p00,
  input  logic [brr_pkg::PIXEL_W-1:0]  p10,
  input  logic [brr_pkg::PIXEL_W-1:0]  p01,
  input  logic [brr_pkg::PIXEL_W-1:0]  p11,
  input  logic [brr_pkg::FRAC_W-1:0]   fx,
  input  logic [brr_pkg::FRAC_W-1:0]   fy,
  output logic [brr_pkg::PIXEL_W-1:0]  pixel
);
  import brr_pkg::*;

  logic [FRAC_W:0]   wx;
  logic [FRAC_W:0]   wy;
  logic [15:0]       row_top [CHANNELS];
  logic [15:0]       row_bot [CHANNELS];
  logic [FRAC_W-1:0] fy_q;

  assign wx = 9'd256 - {1'b0, fx};
  assign wy = 9'd256 - {1'b0, fy_q};

  always_ff @(posedge clk) begin
    if (en) begin
      fy_q <= fy;
      for (int c = 0; c < CHANNELS; c++) begin
        row_top[c] <= {8'b0, p00[c*CHAN_W +: CHAN_W]} * {7'b0, wx}
                    + {8'b0, p10[c*CHAN_W +: CHAN_W]} * {8'b0, fx};
        row_bot[c] <= {8'b0, p01[c*CHAN_W +: CHAN_W]} * {7'b0, wx}
                    + {8'b0, p11[c*CHAN_W +: CHAN_W]} * {8'b0, fx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pixel[c*CHAN_W +: CHAN_W] <= 8'(({8'b0, row_top[c]} * {15'b0, wy}
                                     + {8'b0, row_bot[c]} * {16'b0, fy_q}) >> 16);
      end
    end
  end

endmodule

// ===== rtl/brr_checker.sv =====
// ----------------------------------------------------------------------------
// brr_checker
// Port-level checks of the resize core, bound to the top level.
// ----------------------------------------------------------------------------
module brr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [23:0]                     m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output transaction changed while stalled");

  a_in_flow: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input stalled without a held output");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind bilinear_resize_rgb_core brr_checker u_brr_checker (.*);
